FILE: rtl/core/bmo_pkg.sv
// ----------------------------------------------------------------------------
// bmo_pkg
// shared constants, types and helpers of the binary opening block
// ----------------------------------------------------------------------------
package bmo_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int KERNEL_SIZE = 5;
  localparam int KR          = KERNEL_SIZE / 2;
  localparam int K2          = KERNEL_SIZE * KERNEL_SIZE;

  localparam int PIX_W      = 8;
  localparam int CFG_DIM_W  = 11;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int DIM_W      = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W     = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W      = $clog2(MAX_HEIGHT) + 4;
  localparam int N_W        = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int T_W        = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * (KR * MAX_WIDTH + KR) + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam logic [PIX_W-1:0]     FG_VALUE  = 8'd255;
  localparam logic [CFG_DIM_W-1:0] RESET_DIM = 11'd1024;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KERNEL_MASK  = 2'd2;

  typedef struct packed {
    logic                    pix;
    logic signed [ROW_W-1:0] row;
    logic [COL_W-1:0]        col;
  } tok_t;

  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [HDIM_W-1:0] height;
    logic [K2-1:0]     mask;
  } geom_t;

  function automatic logic [DIM_W-1:0] clamp_w(input logic [CFG_DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (32'(v) > MAX_WIDTH) r = DIM_W'(MAX_WIDTH);
    else r = DIM_W'(v);
    return r;
  endfunction

  function automatic logic [HDIM_W-1:0] clamp_h(input logic [CFG_DIM_W-1:0] v);
    logic [HDIM_W-1:0] r;
    if (v == '0) r = HDIM_W'(1);
    else if (32'(v) > MAX_HEIGHT) r = HDIM_W'(MAX_HEIGHT);
    else r = HDIM_W'(v);
    return r;
  endfunction

  // position of the window center: kr rows and kr pixels back in raster order
  function automatic tok_t step_back(input tok_t p, input logic [DIM_W-1:0] w);
    tok_t c;
    c = p;
    for (int i = 0; i < KR; i++) begin
      if (c.col == '0) begin
        c.col = COL_W'(w - 1'b1);
        c.row = c.row - 2'sd1;
      end else begin
        c.col = c.col - 1'b1;
      end
    end
    c.row = c.row - ROW_W'(KR);
    return c;
  endfunction

endpackage

FILE: rtl/core/bmo_in_if.sv
// ----------------------------------------------------------------------------
// bmo_in_if
// input item channel: pixel or drain tick
// ----------------------------------------------------------------------------
interface bmo_in_if import bmo_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [PIX_W-1:0] pixel_value;
  logic             frame_start;

  modport source(output valid, kind, pixel_value, frame_start, input ready);
  modport sink(input valid, kind, pixel_value, frame_start, output ready);
endinterface

FILE: rtl/core/bmo_out_if.sv
// ----------------------------------------------------------------------------
// bmo_out_if
// result item channel: opened pixel
// ----------------------------------------------------------------------------
interface bmo_out_if import bmo_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;
  logic             out_last;

  modport source(output valid, out_pixel, out_last, input ready);
  modport sink(input valid, out_pixel, out_last, output ready);
endinterface

FILE: rtl/core/bmo_ram.sv
// ----------------------------------------------------------------------------
// bmo_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module bmo_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: rtl/core/bmo_front.sv
// ----------------------------------------------------------------------------
// bmo_front
// accepts items, tracks the raster position and issues work tokens
// ----------------------------------------------------------------------------
module bmo_front import bmo_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  bmo_in_if.sink         pix_in,
  input  geom_t          geom,
  input  logic [N_W-1:0] n_val,
  input  logic [T_W-1:0] end_val,
  input  logic           full,
  output logic           push,
  output tok_t           push_tok
);
  logic [T_W-1:0]          t, tc;
  logic signed [ROW_W-1:0] t_row, rc;
  logic [COL_W-1:0]        t_col, cc;
  logic                    acc, is_pix, start, in_frame, advance;

  assign pix_in.ready = !full;
  assign acc          = pix_in.valid && pix_in.ready;
  assign is_pix       = !pix_in.kind;
  assign start        = is_pix && pix_in.frame_start;

  always_comb begin
    tc       = start ? '0 : t;
    rc       = start ? '0 : t_row;
    cc       = start ? '0 : t_col;
    in_frame = tc < T_W'(n_val);
    advance  = (tc < end_val) && (is_pix || !in_frame);
    push     = acc && advance;
    push_tok.pix = is_pix && in_frame && (pix_in.pixel_value == FG_VALUE);
    push_tok.row = rc;
    push_tok.col = cc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t     <= '0;
      t_row <= '0;
      t_col <= '0;
    end else if (push) begin
      t <= tc + 1'b1;
      if (cc == COL_W'(geom.width - 1'b1)) begin
        t_col <= '0;
        t_row <= rc + 2'sd1;
      end else begin
        t_col <= cc + 1'b1;
        t_row <= rc;
      end
    end
  end
endmodule

FILE: rtl/core/bmo_fifo.sv
// ----------------------------------------------------------------------------
// bmo_fifo
// short token queue between front and back
// ----------------------------------------------------------------------------
module bmo_fifo import bmo_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tok_t push_tok,
  input  logic pop,
  output logic full,
  output logic empty,
  output tok_t head
);
  localparam int PTR_W = $clog2(FIFO_DEPTH);

  tok_t             slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   cnt;
  logic             do_pop;

  assign full   = cnt == (PTR_W + 1)'(FIFO_DEPTH);
  assign empty  = cnt == '0;
  assign head   = slots[rd_ptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      cnt <= cnt + (PTR_W + 1)'(push) - (PTR_W + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (PTR_W + 1)'(FIFO_DEPTH)) else $error("token queue count out of range");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    full && !do_pop |=> cnt == (PTR_W + 1)'(FIFO_DEPTH)) else $error("token queue overrun");
  a_rst_empty: assert property (@(posedge clk)
    rst |=> empty) else $error("token queue not empty after reset");
endmodule

FILE: rtl/core/bmo_pass.sv
// ----------------------------------------------------------------------------
// bmo_pass
// one 5x5 pass: line buffer, window and masked erode or dilate test
// ----------------------------------------------------------------------------
module bmo_pass import bmo_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  dilate,
  input  geom_t geom,
  input  logic  in_valid,
  input  tok_t  in_tok,
  output logic  out_valid,
  output tok_t  out_tok
);
  logic                     v0, v1, we, byp;
  tok_t                     tok0, tok1, ctr, res_tok;
  logic [KERNEL_SIZE-2:0]   rdata, taps, wdata, byp_data;
  logic [KERNEL_SIZE-1:0]   win [KERNEL_SIZE];
  logic [KERNEL_SIZE-1:0]   new_col;
  logic                     hit_all, hit_any;

  assign we = en && v0;

  bmo_ram #(.WIDTH(KERNEL_SIZE - 1), .DEPTH(MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (we),
    .waddr (tok0.col),
    .wdata (wdata),
    .re    (en),
    .raddr (in_tok.col),
    .rdata (rdata)
  );

  assign taps  = byp ? byp_data : rdata;
  assign wdata = {taps[KERNEL_SIZE-3:0], tok0.pix};

  always_comb begin
    new_col[KERNEL_SIZE-1] = tok0.pix;
    for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
      new_col[j] = taps[KERNEL_SIZE-2-j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0        <= in_valid;
      v1        <= v0;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok0     <= in_tok;
      byp      <= we && in_valid && (in_tok.col == tok0.col);
      byp_data <= wdata;
      tok1     <= tok0;
      out_tok  <= res_tok;
      if (v0) begin
        for (int k = 0; k < KERNEL_SIZE - 1; k++) begin
          win[k] <= win[k+1];
        end
        win[KERNEL_SIZE-1] <= new_col;
      end
    end
  end

  always_comb begin
    int   iy, ix;
    logic inf, b;
    ctr     = step_back(tok1, geom.width);
    hit_all = 1'b1;
    hit_any = 1'b0;
    for (int ky = 0; ky < KERNEL_SIZE; ky++) begin
      for (int kx = 0; kx < KERNEL_SIZE; kx++) begin
        iy  = int'(ctr.row) + ky - KR;
        ix  = int'(ctr.col) + kx - KR;
        inf = iy >= 0 && iy < int'(geom.height) && ix >= 0 && ix < int'(geom.width);
        b   = win[kx][ky] && inf;
        if (geom.mask[ky*KERNEL_SIZE+kx]) begin
          if (!b) hit_all = 1'b0;
          if (b) hit_any = 1'b1;
        end
      end
    end
    res_tok     = ctr;
    res_tok.pix = dilate ? hit_any : hit_all;
  end
endmodule

FILE: rtl/core/binary_morphological_opening.sv
// ----------------------------------------------------------------------------
// binary_morphological_opening
// streaming 5x5 binary opening (erode then dilate) of 8-bit pixels
// ----------------------------------------------------------------------------
// pix_in carries pixels in raster order (kind 0) or drain ticks (kind 1);
// frame_start on a pixel restarts the frame. only 255 counts as foreground.
// pix_out gives 0 or 255 per frame position, out_last on the final one.
// a result follows its input position by 4 rows plus 4 pixels of items,
// then passes the pipeline registers of both passes; after the last pixel
// drain ticks push out the remaining rows.
// throughput is one item per clock unless stalled: each pass reads and writes
// its line buffer ram once per item, and the 25 window tests run in parallel.
// a 4-entry token queue lets the input side run on while the output stalls;
// pix_in.ready drops only once that queue is full.
// image_width, image_height and kernel_mask are written over the apb port at
// 0x0, 0x4 and 0x8; the user writes them only while the block is idle, which the block itself does not enforce.
// reset (rst, synchronous) clears position counters, queue and pipeline
// and loads 1024 x 1024 with a full mask; line buffers are not cleared.
// ----------------------------------------------------------------------------
module binary_morphological_opening import bmo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  bmo_in_if.sink             pix_in,
  bmo_out_if.source          pix_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);
  logic [CFG_DIM_W-1:0] cfg_width, cfg_height;
  logic [K2-1:0]        cfg_mask;
  geom_t                geom;
  logic [N_W-1:0]       n_val;
  logic [T_W-1:0]       end_val;
  logic                 wr_en;
  logic [1:0]           reg_idx;

  logic push, full, empty, en, p1_valid, p2_valid;
  tok_t push_tok, head, p1_tok, p2_tok;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= RESET_DIM;
      cfg_height <= RESET_DIM;
      cfg_mask   <= '1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:  cfg_width  <= pwdata[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_height <= pwdata[CFG_DIM_W-1:0];
        REG_KERNEL_MASK:  cfg_mask   <= pwdata[K2-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = PDATA_W'(cfg_width);
      REG_IMAGE_HEIGHT: prdata = PDATA_W'(cfg_height);
      REG_KERNEL_MASK:  prdata = PDATA_W'(cfg_mask);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    geom.width  = clamp_w(cfg_width);
    geom.height = clamp_h(cfg_height);
    geom.mask   = cfg_mask;
    n_val       = N_W'(geom.width * geom.height);
    end_val     = T_W'(n_val) + T_W'(2 * KR * geom.width) + T_W'(2 * KR);
  end

  bmo_front u_front (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix_in),
    .geom     (geom),
    .n_val    (n_val),
    .end_val  (end_val),
    .full     (full),
    .push     (push),
    .push_tok (push_tok)
  );

  bmo_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (push_tok),
    .pop      (en),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  assign en = !pix_out.valid || pix_out.ready;

  bmo_pass u_erode (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .dilate    (1'b0),
    .geom      (geom),
    .in_valid  (!empty),
    .in_tok    (head),
    .out_valid (p1_valid),
    .out_tok   (p1_tok)
  );

  bmo_pass u_dilate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .dilate    (1'b1),
    .geom      (geom),
    .in_valid  (p1_valid),
    .in_tok    (p1_tok),
    .out_valid (p2_valid),
    .out_tok   (p2_tok)
  );

  assign pix_out.valid     = p2_valid && p2_tok.row >= 0
                             && p2_tok.row < $signed(ROW_W'(geom.height));
  assign pix_out.out_pixel = p2_tok.pix ? FG_VALUE : '0;
  assign pix_out.out_last  = p2_tok.row == $signed(ROW_W'(geom.height - 1'b1))
                             && p2_tok.col == COL_W'(geom.width - 1'b1);

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !pix_out.valid) else $error("result valid right after reset");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    p2_valid && !en |=> p2_valid && $stable(p2_tok)) else $error("result lost under stall");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    full |-> !pix_in.ready) else $error("input taken with full queue");
endmodule
